// File: rtl/tscn_pkg.sv
// Package with shared types, character constants and case functions for the normalizer.
package tscn_pkg;

    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_PERIOD = 8'h2E;
    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] CASE_DELTA  = 8'h20;

    typedef struct packed {
        logic       two;
        logic [7:0] byte0;
        logic       end0;
        logic [7:0] byte1;
        logic       end1;
    } t_cmd;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7A) begin
            r = c - CASE_DELTA;
        end
        return r;
    endfunction

    function automatic logic [7:0] downcase(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + CASE_DELTA;
        end
        return r;
    endfunction

endpackage

// File: rtl/tscn_front.sv
// Front stage: holds the spacing flags and turns each input byte into an output command; a space only sets the flags.
module tscn_front
    import tscn_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_text_byte,
    input  logic       i_end_of_text,
    output logic       o_cmd_valid,
    output t_cmd       o_cmd
);

    logic r_nothing_emitted;
    logic r_space_pending;
    logic r_pending_from_input;
    logic n_nothing_emitted;
    logic n_space_pending;
    logic n_pending_from_input;

    always_comb begin
        n_nothing_emitted    = r_nothing_emitted;
        n_space_pending      = r_space_pending;
        n_pending_from_input = r_pending_from_input;
        o_cmd_valid          = 1'b0;
        o_cmd.two            = 1'b0;
        o_cmd.byte0          = CHAR_NUL;
        o_cmd.end0           = 1'b0;
        o_cmd.byte1          = CHAR_NUL;
        o_cmd.end1           = 1'b0;
        if (i_end_of_text) begin
            o_cmd_valid = 1'b1;
            if (r_space_pending && r_pending_from_input) begin
                o_cmd.two   = 1'b1;
                o_cmd.byte0 = CHAR_SPACE;
                o_cmd.end1  = 1'b1;
            end else begin
                o_cmd.end0 = 1'b1;
            end
            n_nothing_emitted    = 1'b1;
            n_space_pending      = 1'b0;
            n_pending_from_input = 1'b0;
        end else if (i_text_byte == CHAR_SPACE) begin
            if (!r_nothing_emitted) begin
                n_space_pending      = 1'b1;
                n_pending_from_input = 1'b1;
            end
        end else if (i_text_byte == CHAR_PERIOD) begin
            o_cmd_valid          = 1'b1;
            o_cmd.byte0          = CHAR_PERIOD;
            n_nothing_emitted    = 1'b0;
            n_space_pending      = 1'b1;
            n_pending_from_input = 1'b0;
        end else begin
            o_cmd_valid = 1'b1;
            if (r_space_pending) begin
                o_cmd.two   = 1'b1;
                o_cmd.byte0 = CHAR_SPACE;
                o_cmd.byte1 = upcase(i_text_byte);
            end else if (r_nothing_emitted) begin
                o_cmd.byte0 = upcase(i_text_byte);
            end else begin
                o_cmd.byte0 = downcase(i_text_byte);
            end
            n_nothing_emitted    = 1'b0;
            n_space_pending      = 1'b0;
            n_pending_from_input = 1'b0;
        end
        o_cmd_valid = o_cmd_valid && i_accept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nothing_emitted    <= 1'b1;
            r_space_pending      <= 1'b0;
            r_pending_from_input <= 1'b0;
        end else if (i_accept) begin
            r_nothing_emitted    <= n_nothing_emitted;
            r_space_pending      <= n_space_pending;
            r_pending_from_input <= n_pending_from_input;
        end
    end

endmodule

// File: rtl/tscn_queue.sv
// Command queue between the front and back stages.
module tscn_queue
    import tscn_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_cmd i_wr_cmd,
    input  logic i_rd,
    output t_cmd o_rd_cmd,
    output logic o_full,
    output logic o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          wr_en;
    logic          rd_en;

    assign o_full   = (r_count == FULL_COUNT);
    assign o_empty  = (r_count == '0);
    assign wr_en    = i_wr && !o_full;
    assign rd_en    = i_rd && !o_empty;
    assign o_rd_cmd = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: rtl/tscn_back.sv
// Back stage: expands each command into one or two results in an output register.
module tscn_back
    import tscn_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_cmd_rd,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [7:0] o_out_byte,
    output logic       o_out_end
);

    logic       r_half;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_end;
    logic       load;
    logic       take;

    assign load       = !r_out_valid || i_pop;
    assign take       = load && i_cmd_valid;
    assign o_cmd_rd   = take && (!i_cmd.two || r_half);
    assign o_empty    = !r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_out_end  = r_out_end;

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_byte <= r_half ? i_cmd.byte1 : i_cmd.byte0;
            r_out_end  <= r_half ? i_cmd.end1 : i_cmd.end0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= i_cmd_valid;
            end
            if (take) begin
                r_half <= i_cmd.two && !r_half;
            end
        end
    end

endmodule

// File: rtl/text_spacing_case_normalizer.sv
// Top level of the text spacing and case normalizer.
//
//  Channel   Direction  Handshake               Payload
//  input     in         push / full             i_text_byte, i_end_of_text
//  result    out        empty / pop             o_out_byte, o_out_end
//
// A byte is taken in every cycle that push is high and full is low; the front updates its flags in that cycle.
// A byte that gives two results occupies the back stage for both of them in turn, so the sustained
// rate is one result per cycle while pop is held high; the command queue of CMD_DEPTH entries absorbs bursts.
// A result passes through the command queue and then the output register before it reaches the output.
// Reset is synchronous; both stages stall independently on full and pop.
module text_spacing_case_normalizer
    import tscn_pkg::*;
#(
    parameter int CMD_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_text_byte,
    input  logic       i_end_of_text,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_out_end
);

    logic accept;
    logic w_cmd_valid;
    t_cmd w_cmd;
    t_cmd w_q_cmd;
    logic w_q_full;
    logic w_q_empty;
    logic w_q_rd;

    assign full   = w_q_full;
    assign accept = push && !w_q_full;

    tscn_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .o_cmd_valid   (w_cmd_valid),
        .o_cmd         (w_cmd)
    );

    tscn_queue #(
        .DEPTH (CMD_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (w_cmd_valid),
        .i_wr_cmd (w_cmd),
        .i_rd     (w_q_rd),
        .o_rd_cmd (w_q_cmd),
        .o_full   (w_q_full),
        .o_empty  (w_q_empty)
    );

    tscn_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!w_q_empty),
        .i_cmd       (w_q_cmd),
        .o_cmd_rd    (w_q_rd),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out_byte  (o_out_byte),
        .o_out_end   (o_out_end)
    );

    a_queue_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_full && w_q_empty))
        else $error("command queue reports full and empty together");

    a_end_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_end_of_text |=> !w_q_empty)
        else $error("end marker transfer did not reach the command queue");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("output not empty after reset");

endmodule

// File: dv/tb.sv
// Self-checking testbench for the text spacing and case normalizer.
`timescale 1ns / 100ps

module tb;
    import tscn_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int ITEM_TARGET = 550;
    localparam int END_WAIT = 20;

    typedef struct packed {
        logic [7:0] chr;
        logic       eot;
        logic       drain;
        logic [7:0] gap;
    } t_feed;

    typedef struct packed {
        logic [7:0] chr;
        logic       fin;
    } t_norm;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] i_text_byte = 8'h00;
    logic       i_end_of_text = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_out_end;

    t_feed byte_q[$];
    t_norm norm_q[$];

    logic at_start = 1'b1;
    logic held_space = 1'b0;
    logic held_from_input = 1'b0;

    logic calm_feed = 1'b0;
    logic calm_pop = 1'b0;
    int   calm_left = 0;
    int   wait_cnt = 0;
    int   stall_cnt = 0;
    int   idle_cnt = 0;
    int   n_items = 0;
    int   n_in = 0;
    int   n_out = 0;
    int   n_texts = 0;
    int   n_pairs = 0;
    int   errors = 0;

    text_spacing_case_normalizer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .empty         (empty),
        .pop           (pop),
        .o_out_byte    (o_out_byte),
        .o_out_end     (o_out_end)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int draw_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 2);
        end else if (r < 96) begin
            return $urandom_range(3, 8);
        end
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        if (c >= "a" && c <= "z") begin
            return c & 8'hDF;
        end
        return c;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        if (c >= "A" && c <= "Z") begin
            return c | 8'h20;
        end
        return c;
    endfunction

    function automatic void queue_result(input logic [7:0] b, input logic fin);
        t_norm r;
        r.chr = b;
        r.fin = fin;
        norm_q.push_back(r);
    endfunction

    function automatic void normalize_byte(input logic [7:0] c, input logic eot);
        if (eot) begin
            if (held_space && held_from_input) begin
                queue_result(CHAR_SPACE, 1'b0);
            end
            queue_result(CHAR_NUL, 1'b1);
            at_start = 1'b1;
            held_space = 1'b0;
            held_from_input = 1'b0;
            n_texts++;
        end else if (c == CHAR_SPACE) begin
            if (!at_start) begin
                held_space = 1'b1;
                held_from_input = 1'b1;
            end
        end else if (c == CHAR_PERIOD) begin
            queue_result(CHAR_PERIOD, 1'b0);
            at_start = 1'b0;
            held_space = 1'b1;
            held_from_input = 1'b0;
        end else begin
            if (held_space) begin
                queue_result(CHAR_SPACE, 1'b0);
                queue_result(to_upper(c), 1'b0);
                n_pairs++;
            end else if (at_start) begin
                queue_result(to_upper(c), 1'b0);
            end else begin
                queue_result(to_lower(c), 1'b0);
            end
            at_start = 1'b0;
            held_space = 1'b0;
            held_from_input = 1'b0;
        end
    endfunction

    function automatic logic [7:0] rand_char();
        int r;
        r = $urandom_range(99);
        if (r < 28) begin
            return CHAR_SPACE;
        end else if (r < 38) begin
            return CHAR_PERIOD;
        end else if (r < 58) begin
            return 8'("a" + $urandom_range(25));
        end else if (r < 78) begin
            return 8'("A" + $urandom_range(25));
        end else if (r < 84) begin
            case ($urandom_range(3))
                0: return 8'h40;
                1: return 8'h5B;
                2: return 8'h60;
                default: return 8'h7B;
            endcase
        end
        return 8'($urandom_range(255));
    endfunction

    task automatic add_item(input logic [7:0] b, input logic eot, input logic drain);
        t_feed f;
        f.chr = b;
        f.eot = eot;
        f.drain = drain;
        f.gap = calm_feed ? 8'd0 : 8'(draw_gap());
        byte_q.push_back(f);
        n_items++;
    endtask

    task automatic add_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            add_item(s[k], 1'b0, 1'b0);
        end
    endtask

    // Sender: presents the head of the pending queue, with gaps and drain pauses.
    always @(posedge i_clk) begin : drive_proc
        logic  fire;
        t_feed head;
        fire = push && !full;
        if (i_rst_n) begin
            if (fire) begin
                normalize_byte(i_text_byte, i_end_of_text);
                void'(byte_q.pop_front());
                n_in++;
                if (byte_q.size() != 0) begin
                    head = byte_q[0];
                    wait_cnt = int'(head.gap);
                end
            end
            if (push && !fire) begin
                push <= 1'b1;
            end else if (byte_q.size() == 0) begin
                push <= 1'b0;
            end else if (wait_cnt > 0) begin
                wait_cnt--;
                push <= 1'b0;
            end else begin
                head = byte_q[0];
                if (head.drain && norm_q.size() != 0) begin
                    push <= 1'b0;
                end else begin
                    push <= 1'b1;
                    i_text_byte <= head.chr;
                    i_end_of_text <= head.eot;
                end
            end
        end
    end

    // Receiver: pops with random stalls and checks each transfer against the oldest expectation.
    always @(posedge i_clk) begin : check_proc
        t_norm want;
        if (i_rst_n) begin
            if (pop && !empty) begin
                n_out++;
                if (norm_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual byte %h end %b",
                             $time, o_out_byte, o_out_end);
                end else begin
                    want = norm_q.pop_front();
                    if (want.chr !== o_out_byte) begin
                        errors++;
                        $display("%0t: out_byte mismatch, expected %h, actual %h",
                                 $time, want.chr, o_out_byte);
                    end
                    if (want.fin !== o_out_end) begin
                        errors++;
                        $display("%0t: out_end mismatch, expected %b, actual %b",
                                 $time, want.fin, o_out_end);
                    end
                end
                if (calm_left == 0) begin
                    calm_left = $urandom_range(30, 80);
                    calm_pop = ($urandom_range(2) == 0);
                end
                calm_left--;
                stall_cnt = calm_pop ? 0 : draw_gap();
            end
            if (stall_cnt > 0) begin
                stall_cnt--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : watchdog_proc
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty)) begin
                idle_cnt = 0;
            end else begin
                idle_cnt++;
            end
            if (idle_cnt >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d results still expected",
                         $time, IDLE_LIMIT, norm_q.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin : stim_proc
        int  text_len;
        int  gen_texts;
        logic noise;
        // Leading spaces, collapsed runs, space before a period, forced and input spaces
        // after a period, and a trailing input space kept at the end.
        add_text("  hEL  w .a. z ");
        add_item(8'h00, 1'b1, 1'b0);
        // A text that ends right after a period drops the forced space.
        add_text(".");
        add_item("a", 1'b1, 1'b1);
        add_item(8'h00, 1'b0, 1'b0);
        add_item(8'hFF, 1'b0, 1'b0);
        add_item("Z", 1'b0, 1'b0);
        add_item("@", 1'b0, 1'b0);
        add_item("{", 1'b0, 1'b0);
        add_item(8'hFF, 1'b1, 1'b0);
        add_item(8'h55, 1'b1, 1'b0);

        gen_texts = 0;
        while (n_items < ITEM_TARGET) begin
            calm_feed = ($urandom_range(4) == 0);
            noise = ($urandom_range(9) == 0);
            text_len = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 18);
            for (int k = 0; k < text_len; k++) begin
                add_item(noise ? 8'($urandom_range(255)) : rand_char(), 1'b0,
                         (k == 0) && (gen_texts % 9 == 0));
            end
            add_item(8'($urandom_range(255)), 1'b1,
                     (text_len == 0) && (gen_texts % 9 == 0));
            gen_texts++;
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_q.size() != 0 || push) @(posedge i_clk);
        while (norm_q.size() != 0) @(posedge i_clk);
        repeat (END_WAIT) @(posedge i_clk);

        $display("Covered %0d input transfers in %0d texts and %0d result transfers,",
                 n_in, n_texts, n_out);
        $display("with %0d bytes that each released a held space; %0d mismatches.",
                 n_pairs, errors);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
